>>> rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Word types, sector codes and arithmetic constants shared by the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  typedef struct packed {
    logic [15:0] hue_deg;
    logic [7:0]  sat_pct;
    logic [7:0]  val_pct;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgb_word_t;

  // Sector codes, one per 60-degree slice of the hue circle.
  localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    logic [2:0] sector;
    logic [5:0] offset;
    logic [6:0] sat;
    logic [6:0] val;
  } cls_word_t;

  typedef struct packed {
    logic empty;
    logic nearly_full;
  } q_status_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [8:0]  HUE_WRAP   = 9'd360;
  localparam logic [5:0]  SEC_SPAN   = 6'd60;
  localparam logic [12:0] FULL_SCALE = 13'd6000;

  // floor(h / 360) is taken as (h * HUE_RECIP) >> 24 with one correction.
  localparam logic [15:0] HUE_RECIP = 16'd46603;
  // Level = floor(N * 17 / 40000); the divide uses (x * LVL_RECIP) >> 32.
  localparam logic [16:0] LVL_RECIP = 17'd107374;
  localparam logic [15:0] LVL_DIV   = 16'd40000;

endpackage

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts hue, saturation and value words to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// The converter takes one word per clock while busy is low and returns each
// result on rgb_o with done_o high for one cycle, in the order the words were
// accepted. The back-end pipeline drains one word per clock, so the queue
// between the two halves never fills and busy stays low in operation; it
// rises only when the queue is within two words of full.
module hsv_to_rgb_converter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  hsv2rgb_pkg::hsv_word_t hsv_i,
  output logic                   busy,
  output logic                   done_o,
  output hsv2rgb_pkg::rgb_word_t rgb_o
);

  logic                   push;
  logic                   pop;
  hsv2rgb_pkg::cls_word_t push_word;
  hsv2rgb_pkg::cls_word_t head;
  hsv2rgb_pkg::q_status_t q_status;

  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .hsv_i       (hsv_i),
    .q_status_i  (q_status),
    .busy        (busy),
    .push_o      (push),
    .push_word_o (push_word)
  );

  hsv2rgb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  hsv2rgb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .done_o     (done_o),
    .rgb_o      (rgb_o)
  );

endmodule

>>> rtl/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter front end
// Accepts words, clamps the percentages and splits the hue into a sector and
// an offset within it.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  hsv2rgb_pkg::hsv_word_t hsv_i,
  input  hsv2rgb_pkg::q_status_t q_status_i,
  output logic                   busy,
  output logic                   push_o,
  output hsv2rgb_pkg::cls_word_t push_word_o
);

  logic        vld_q;
  logic [15:0] hue_q;
  logic [7:0]  quo_q;
  logic [6:0]  sat_q;
  logic [6:0]  val_q;
  logic [31:0] hue_prod;
  logic [16:0] hue_rem_wide;
  logic [9:0]  hue_rem;
  logic [8:0]  hue_red;
  logic [2:0]  sector;
  logic [8:0]  sec_base;

  assign busy     = q_status_i.nearly_full;
  assign hue_prod = 32'(hsv_i.hue_deg) * 32'(hsv2rgb_pkg::HUE_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      hue_q <= hsv_i.hue_deg;
      quo_q <= hue_prod[31:24];
      sat_q <= (hsv_i.sat_pct > 8'(hsv2rgb_pkg::PCT_MAX)) ? hsv2rgb_pkg::PCT_MAX
                                                          : hsv_i.sat_pct[6:0];
      val_q <= (hsv_i.val_pct > 8'(hsv2rgb_pkg::PCT_MAX)) ? hsv2rgb_pkg::PCT_MAX
                                                          : hsv_i.val_pct[6:0];
    end
  end

  assign hue_rem_wide = {1'b0, hue_q} - 17'(quo_q) * 17'(hsv2rgb_pkg::HUE_WRAP);
  assign hue_rem      = hue_rem_wide[9:0];
  assign hue_red      = (hue_rem >= 10'(hsv2rgb_pkg::HUE_WRAP))
                        ? 9'(hue_rem - 10'(hsv2rgb_pkg::HUE_WRAP)) : hue_rem[8:0];

  always_comb begin
    if (hue_red >= 9'd300) begin
      sector   = hsv2rgb_pkg::SEC_MAGENTA_RED;
      sec_base = 9'd300;
    end else if (hue_red >= 9'd240) begin
      sector   = hsv2rgb_pkg::SEC_BLUE_MAGENTA;
      sec_base = 9'd240;
    end else if (hue_red >= 9'd180) begin
      sector   = hsv2rgb_pkg::SEC_CYAN_BLUE;
      sec_base = 9'd180;
    end else if (hue_red >= 9'd120) begin
      sector   = hsv2rgb_pkg::SEC_GREEN_CYAN;
      sec_base = 9'd120;
    end else if (hue_red >= 9'd60) begin
      sector   = hsv2rgb_pkg::SEC_YELLOW_GREEN;
      sec_base = 9'd60;
    end else begin
      sector   = hsv2rgb_pkg::SEC_RED_YELLOW;
      sec_base = 9'd0;
    end
  end

  assign push_o             = vld_q;
  assign push_word_o.sector = sector;
  assign push_word_o.offset = 6'(hue_red - sec_base);
  assign push_word_o.sat    = sat_q;
  assign push_word_o.val    = val_q;

endmodule

>>> rtl/hsv2rgb_queue.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter word queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hsv2rgb_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hsv2rgb_pkg::cls_word_t push_word_i,
  input  logic                   pop_i,
  output hsv2rgb_pkg::cls_word_t head_o,
  output hsv2rgb_pkg::q_status_t status_o
);

  localparam int unsigned QCntW = hsv2rgb_pkg::QCntW;

  hsv2rgb_pkg::cls_word_t               mem_q [hsv2rgb_pkg::QDepth];
  logic [hsv2rgb_pkg::QPtrW-1:0]        wr_ptr_q;
  logic [hsv2rgb_pkg::QPtrW-1:0]        rd_ptr_q;
  logic [hsv2rgb_pkg::QCntW-1:0]        count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign head_o               = mem_q[rd_ptr_q];
  assign status_o.empty       = (count_q == '0);
  assign status_o.nearly_full = (count_q >= QCntW'(hsv2rgb_pkg::QDepth - 2));

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < QCntW'(hsv2rgb_pkg::QDepth))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill count lost a write");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(hsv2rgb_pkg::QDepth))
    else $error("queue fill count out of range");

endmodule

>>> rtl/hsv2rgb_back.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter back end
// Forms the p, q and t levels, orders them by sector and scales each channel
// to eight bits through an exact reciprocal divide.
// ----------------------------------------------------------------------------
module hsv2rgb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsv2rgb_pkg::cls_word_t head_i,
  input  hsv2rgb_pkg::q_status_t q_status_i,
  output logic                   pop_o,
  output logic                   done_o,
  output hsv2rgb_pkg::rgb_word_t rgb_o
);

  logic              a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic [2:0]        a_sec_q, b_sec_q;
  logic [6:0]        a_val_q;
  logic [12:0]       a_low_q, a_fall_q, a_rise_q;
  logic [19:0]       b_full_q, b_low_q, b_fall_q, b_rise_q;
  logic [2:0][19:0]  c_num;
  logic [2:0][23:0]  c_x_q;
  logic [2:0][23:0]  d_x_q;
  logic [2:0][7:0]   d_quo_q;
  logic [2:0][40:0]  d_prod;
  logic [2:0][23:0]  e_rem;
  logic [2:0][7:0]   e_lvl;
  logic [2:0][7:0]   lvl_q;
  logic [5:0]        rise_off;

  assign pop_o    = !q_status_i.empty;
  assign rise_off = hsv2rgb_pkg::SEC_SPAN - head_i.offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      a_vld_q <= pop_o;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sec_q  <= head_i.sector;
    a_val_q  <= head_i.val;
    a_low_q  <= 13'(hsv2rgb_pkg::PCT_MAX - head_i.sat) * 13'(hsv2rgb_pkg::SEC_SPAN);
    a_fall_q <= hsv2rgb_pkg::FULL_SCALE - 13'(head_i.sat) * 13'(head_i.offset);
    a_rise_q <= hsv2rgb_pkg::FULL_SCALE - 13'(head_i.sat) * 13'(rise_off);

    b_sec_q  <= a_sec_q;
    b_full_q <= 20'(a_val_q) * 20'(hsv2rgb_pkg::FULL_SCALE);
    b_low_q  <= 20'(a_val_q) * 20'(a_low_q);
    b_fall_q <= 20'(a_val_q) * 20'(a_fall_q);
    b_rise_q <= 20'(a_val_q) * 20'(a_rise_q);
  end

  always_comb begin
    unique case (b_sec_q)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        c_num = {b_full_q, b_rise_q, b_low_q};
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        c_num = {b_fall_q, b_full_q, b_low_q};
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        c_num = {b_low_q, b_full_q, b_rise_q};
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        c_num = {b_low_q, b_fall_q, b_full_q};
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        c_num = {b_rise_q, b_low_q, b_full_q};
      end
      default: begin
        c_num = {b_full_q, b_low_q, b_fall_q};
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_prod[i] = 41'(c_x_q[i]) * 41'(hsv2rgb_pkg::LVL_RECIP);
      e_rem[i]  = d_x_q[i] - 24'(d_quo_q[i]) * 24'(hsv2rgb_pkg::LVL_DIV);
      e_lvl[i]  = d_quo_q[i] + 8'(e_rem[i] >= 24'(hsv2rgb_pkg::LVL_DIV));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c_x_q[i]   <= {c_num[i], 4'b0000} + 24'(c_num[i]);
      d_x_q[i]   <= c_x_q[i];
      d_quo_q[i] <= d_prod[i][39:32];
      lvl_q[i]   <= e_lvl[i];
    end
  end

  assign done_o          = e_vld_q;
  assign rgb_o.red_out   = lvl_q[2];
  assign rgb_o.green_out = lvl_q[1];
  assign rgb_o.blue_out  = lvl_q[0];

  a_pipe_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ##5 done_o)
    else $error("popped word did not reach the output");

  a_no_orphan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(pop_o, 5))
    else $error("result strobe without a popped word");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> e_rem[0] < 24'(2 * 40000) && e_rem[1] < 24'(2 * 40000)
                && e_rem[2] < 24'(2 * 40000))
    else $error("reciprocal divide needs more than one correction");

endmodule

>>> tb/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends hue, saturation and value words through the converter and checks each
// returned colour word against a predictor built from exact integer arithmetic.
// Directed words cover every sector edge, hue wrap-around and percent clamping,
// followed by random words with and without gaps on the sending side.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

  typedef struct {
    hsv2rgb_pkg::hsv_word_t src;
    hsv2rgb_pkg::rgb_word_t rgb;
  } pending_rgb_t;

  localparam int unsigned LEVEL_DEN = 600000;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  hsv2rgb_pkg::hsv_word_t hsv_i;
  logic                   busy;
  logic                   done_o;
  hsv2rgb_pkg::rgb_word_t rgb_o;

  pending_rgb_t expected_rgb[$];

  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned hue_wraps;
  int unsigned pct_clamps;
  int unsigned mismatch_count;
  int unsigned stray_count;
  bit          gaps_on;

  hsv_to_rgb_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .hsv_i  (hsv_i),
    .busy   (busy),
    .done_o (done_o),
    .rgb_o  (rgb_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] to_level(int unsigned num);
    return 8'((num * 255) / LEVEL_DEN);
  endfunction

  function automatic hsv2rgb_pkg::rgb_word_t hsv_to_rgb_predict(hsv2rgb_pkg::hsv_word_t w);
    int unsigned hue;
    int unsigned sat;
    int unsigned val;
    int unsigned off;
    int unsigned peak;
    int unsigned base_lvl;
    int unsigned ramp_dn;
    int unsigned ramp_up;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    logic [2:0]  sector;
    hsv2rgb_pkg::rgb_word_t res;
    hue = w.hue_deg % hsv2rgb_pkg::HUE_WRAP;
    sat = (w.sat_pct > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : w.sat_pct;
    val = (w.val_pct > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : w.val_pct;
    sector = 3'(hue / hsv2rgb_pkg::SEC_SPAN);
    off = hue % hsv2rgb_pkg::SEC_SPAN;
    peak = val * hsv2rgb_pkg::FULL_SCALE;
    base_lvl = val * (hsv2rgb_pkg::PCT_MAX - sat) * hsv2rgb_pkg::SEC_SPAN;
    ramp_dn = val * (hsv2rgb_pkg::FULL_SCALE - sat * off);
    ramp_up = val * (hsv2rgb_pkg::FULL_SCALE - sat * (hsv2rgb_pkg::SEC_SPAN - off));
    case (sector)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        r = peak; g = ramp_up; b = base_lvl;
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        r = ramp_dn; g = peak; b = base_lvl;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        r = base_lvl; g = peak; b = ramp_up;
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        r = base_lvl; g = ramp_dn; b = peak;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        r = ramp_up; g = base_lvl; b = peak;
      end
      default: begin
        r = peak; g = base_lvl; b = ramp_dn;
      end
    endcase
    res.red_out = to_level(r);
    res.green_out = to_level(g);
    res.blue_out = to_level(b);
    return res;
  endfunction

  task automatic send_word(input logic [15:0] hue, input logic [7:0] sat,
                           input logic [7:0] val);
    hsv2rgb_pkg::hsv_word_t w;
    pending_rgb_t           entry;
    w = {hue, sat, val};
    start <= 1'b1;
    hsv_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    entry.src = w;
    entry.rgb = hsv_to_rgb_predict(w);
    expected_rgb.push_back(entry);
    words_sent++;
    if (hue >= hsv2rgb_pkg::HUE_WRAP) hue_wraps++;
    if (sat > hsv2rgb_pkg::PCT_MAX || val > hsv2rgb_pkg::PCT_MAX) pct_clamps++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic random_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    case ($urandom_range(0, 9))
      0, 1: begin
        hue = 16'($urandom);
        sat = 8'($urandom);
        val = 8'($urandom);
      end
      2: begin
        hue = 16'($urandom_range(0, 5) * hsv2rgb_pkg::SEC_SPAN
                  + $urandom_range(0, 1) * 59);
        sat = 8'($urandom_range(95, 110));
        val = 8'($urandom_range(95, 110));
      end
      default: begin
        hue = 16'($urandom_range(0, 719));
        sat = 8'($urandom_range(0, 100));
        val = 8'($urandom_range(0, 100));
      end
    endcase
    send_word(hue, sat, val);
  endtask

  task automatic test_directed();
    send_word(16'd0, 8'd100, 8'd100);
    send_word(16'd59, 8'd100, 8'd100);
    send_word(16'd60, 8'd100, 8'd100);
    send_word(16'd119, 8'd100, 8'd100);
    send_word(16'd120, 8'd100, 8'd100);
    send_word(16'd180, 8'd100, 8'd100);
    send_word(16'd240, 8'd100, 8'd100);
    send_word(16'd299, 8'd100, 8'd100);
    send_word(16'd300, 8'd100, 8'd100);
    send_word(16'd359, 8'd100, 8'd100);
    send_word(16'd360, 8'd100, 8'd100);
    send_word(16'd719, 8'd100, 8'd100);
    send_word(16'd65535, 8'd100, 8'd100);
    send_word(16'd0, 8'd0, 8'd100);
    send_word(16'd200, 8'd0, 8'd50);
    send_word(16'd90, 8'd100, 8'd0);
    send_word(16'd0, 8'd0, 8'd0);
    send_word(16'd45, 8'd101, 8'd100);
    send_word(16'd45, 8'd255, 8'd255);
    send_word(16'd330, 8'd50, 8'd101);
    send_word(16'd65535, 8'd255, 8'd255);
    send_word(16'd30, 8'd37, 8'd73);
    send_word(16'd65280, 8'd85, 8'd170);
    drain_results();
  endtask

  task automatic test_random_with_gaps(input int unsigned count);
    gaps_on = 1'b1;
    repeat (count) begin
      send_random_word();
      random_gap();
    end
  endtask

  task automatic test_sender_drain();
    repeat (20) send_random_word();
    drain_results();
    repeat (20) send_random_word();
  endtask

  task automatic test_back_to_back(input int unsigned count);
    gaps_on = 1'b0;
    repeat (count) send_random_word();
    start <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    pending_rgb_t exp_entry;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_rgb.size() == 0) begin
        stray_count++;
        $display("Unexpected result word: r=%0d g=%0d b=%0d",
                 rgb_o.red_out, rgb_o.green_out, rgb_o.blue_out);
      end else begin
        exp_entry = expected_rgb.pop_front();
        words_checked++;
        if (rgb_o.red_out !== exp_entry.rgb.red_out ||
            rgb_o.green_out !== exp_entry.rgb.green_out ||
            rgb_o.blue_out !== exp_entry.rgb.blue_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch for h=%0d s=%0d v=%0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     exp_entry.src.hue_deg, exp_entry.src.sat_pct,
                     exp_entry.src.val_pct, exp_entry.rgb.red_out,
                     exp_entry.rgb.green_out, exp_entry.rgb.blue_out,
                     rgb_o.red_out, rgb_o.green_out, rgb_o.blue_out);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    hsv_i <= '0;
    gaps_on = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_with_gaps(440);
    test_sender_drain();
    test_back_to_back(150);

    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d of %0d words across all six sectors, with and without gaps.",
             words_checked, words_sent);
    $display("%0d words had a hue that wrapped and %0d had a clamped percentage.",
             hue_wraps, pct_clamps);
    if (mismatch_count == 0 && stray_count == 0 && expected_rgb.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d unexpected words, %0d words missing.",
               mismatch_count, stray_count, expected_rgb.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
